// ===== sv/frx_pkg.sv =====
// shared types, opcodes and status codes of the four-register executor
package frx_pkg;

	localparam int REG_WIDTH = 32;
	localparam int NUM_REGS = 4;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int CNT_W = $clog2(REG_WIDTH);
	localparam int OUT_W = 32;

	typedef logic [REG_WIDTH-1:0] reg_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [3:0] func_t;
	typedef logic [1:0] status_t;

	localparam func_t OP_MOV = 4'd0;
	localparam func_t OP_ADD = 4'd1;
	localparam func_t OP_SUB = 4'd2;
	localparam func_t OP_MUL = 4'd3;
	localparam func_t OP_DIV = 4'd4;
	localparam func_t OP_INC = 4'd5;
	localparam func_t OP_DEC = 4'd6;
	localparam func_t OP_JNZ = 4'd7;
	localparam func_t OP_END = 4'd8;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_END = 2'd1;
	localparam status_t ST_DIVZ = 2'd2;
	localparam status_t ST_SEGV = 2'd3;

	localparam reg_idx_t REG_CX = 2'd2;

	typedef struct packed {
		logic  start;
		func_t op;
	} alu_req_t;

endpackage

// ===== sv/frx_ram.sv =====
// generic single-write, single-read ram with registered read data
module frx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/frx_alu.sv =====
// iterative arithmetic unit: one shared adder for add, sub, shift-add multiply and divide
module frx_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  frx_pkg::alu_req_t req,
	input  frx_pkg::reg_t     cur,
	input  frx_pkg::reg_t     src,
	output logic              done,
	output frx_pkg::reg_t     result
);

	typedef enum logic [6:0] {
		A_IDLE = 7'b0000001,
		A_ONE  = 7'b0000010,
		A_MUL  = 7'b0000100,
		A_NEGA = 7'b0001000,
		A_NEGB = 7'b0010000,
		A_DIV  = 7'b0100000,
		A_NEGQ = 7'b1000000
	} alu_state_t;

	alu_state_t                 state_q;
	frx_pkg::reg_t              a_q;
	frx_pkg::reg_t              b_q;
	frx_pkg::reg_t              acc_q;
	logic [frx_pkg::CNT_W-1:0]  cnt_q;
	frx_pkg::func_t             op_q;
	logic                       neg_a_q;
	logic                       neg_b_q;

	logic [frx_pkg::REG_WIDTH:0]   add_x;
	logic [frx_pkg::REG_WIDTH:0]   add_y;
	logic                          add_c;
	logic [frx_pkg::REG_WIDTH+1:0] sum;
	logic                          carry;
	logic                          neg_quot;

	assign neg_quot = neg_a_q ^ neg_b_q;

	// shared adder operand selection
	always_comb begin
		add_x = '0;
		add_y = '0;
		add_c = 1'b0;
		case (state_q)
			A_ONE: begin
				add_x = {1'b0, a_q};
				case (op_q)
					frx_pkg::OP_MOV: begin
						add_x = '0;
						add_y = {1'b0, b_q};
					end
					frx_pkg::OP_ADD: add_y = {1'b0, b_q};
					frx_pkg::OP_SUB: begin
						add_y = {1'b0, ~b_q};
						add_c = 1'b1;
					end
					frx_pkg::OP_INC: add_c = 1'b1;
					frx_pkg::OP_DEC: add_y = {1'b0, {frx_pkg::REG_WIDTH{1'b1}}};
					default: add_y = '0;
				endcase
			end
			A_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = b_q[0] ? {1'b0, a_q} : '0;
			end
			A_NEGA: begin
				add_y = {1'b0, neg_a_q ? ~a_q : a_q};
				add_c = neg_a_q;
			end
			A_NEGB: begin
				add_y = {1'b0, neg_b_q ? ~b_q : b_q};
				add_c = neg_b_q;
			end
			A_DIV: begin
				// trial subtract of the divisor from the shifted partial remainder
				add_x = {acc_q, a_q[frx_pkg::REG_WIDTH-1]};
				add_y = ~{1'b0, b_q};
				add_c = 1'b1;
			end
			A_NEGQ: begin
				add_y = {1'b0, neg_quot ? ~a_q : a_q};
				add_c = neg_quot;
			end
			default: add_c = 1'b0;
		endcase
	end

	assign sum = {1'b0, add_x} + {1'b0, add_y} + {{(frx_pkg::REG_WIDTH+1){1'b0}}, add_c};
	assign carry = sum[frx_pkg::REG_WIDTH+1];
	assign result = sum[frx_pkg::REG_WIDTH-1:0];
	assign done = (state_q == A_ONE) || (state_q == A_NEGQ) ||
		((state_q == A_MUL) && (cnt_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						cnt_q <= frx_pkg::CNT_W'(frx_pkg::REG_WIDTH - 1);
						if (req.op == frx_pkg::OP_MUL) begin
							state_q <= A_MUL;
						end else if ((req.op == frx_pkg::OP_DIV) && (src != '0)) begin
							state_q <= A_NEGA;
						end else begin
							state_q <= A_ONE;
						end
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= A_IDLE;
					end
				end
				A_NEGA: state_q <= A_NEGB;
				A_NEGB: state_q <= A_DIV;
				A_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= A_NEGQ;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					a_q <= cur;
					b_q <= src;
					acc_q <= '0;
					op_q <= req.op;
					neg_a_q <= cur[frx_pkg::REG_WIDTH-1];
					neg_b_q <= src[frx_pkg::REG_WIDTH-1];
				end
			end
			A_MUL: begin
				acc_q <= sum[frx_pkg::REG_WIDTH-1:0];
				a_q <= {a_q[frx_pkg::REG_WIDTH-2:0], 1'b0};
				b_q <= {1'b0, b_q[frx_pkg::REG_WIDTH-1:1]};
			end
			A_NEGA: a_q <= sum[frx_pkg::REG_WIDTH-1:0];
			A_NEGB: b_q <= sum[frx_pkg::REG_WIDTH-1:0];
			A_DIV: begin
				// keep the difference when no borrow, else the shifted remainder
				acc_q <= carry ? sum[frx_pkg::REG_WIDTH-1:0] : add_x[frx_pkg::REG_WIDTH-1:0];
				a_q <= {a_q[frx_pkg::REG_WIDTH-2:0], carry};
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule

// ===== sv/four_register_instruction_executor.sv =====
// top level: register file, instruction sequencer and result register
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | func dest_reg src_is_reg src_reg immediate
//          |           |                       | target_valid jump_line
//  out     | output    | out_valid / out_stall | status jump_taken jump_target dest_value
//  cfg     | input     | cfg_we                | cfg_wdata (program_lines)
//
// most operations take a single arithmetic step, MUL takes one shift-add step per bit
// and DIV takes sign fix-ups plus one restoring step per bit
// in_stall is high from acceptance until the result is loaded into the output register,
// so the next item is accepted in the cycle after that at the earliest
// a result waiting on out_stall holds the next item off in the write-back step
// reset clears the four registers to zero through per-register valid bits
module four_register_instruction_executor (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [3:0]            func,
	input  logic [1:0]            dest_reg,
	input  logic                  src_is_reg,
	input  logic [1:0]            src_reg,
	input  logic signed [31:0]    immediate,
	input  logic                  target_valid,
	input  logic signed [15:0]    jump_line,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic                  jump_taken,
	output logic [15:0]           jump_target,
	output logic signed [31:0]    dest_value
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RDS  = 5'b00010,
		S_CAP  = 5'b00100,
		S_EXEC = 5'b01000,
		S_WB   = 5'b10000
	} seq_state_t;

	seq_state_t                         state_q;
	logic [15:0]                        program_lines_q;
	logic [frx_pkg::NUM_REGS-1:0]       reg_valid_q;
	frx_pkg::reg_idx_t                  rd_idx_q;
	frx_pkg::reg_idx_t                  raddr;
	frx_pkg::reg_t                      rdata;
	frx_pkg::reg_t                      rd_val;
	logic                               ram_we;

	frx_pkg::func_t                     func_q;
	frx_pkg::reg_idx_t                  dest_q;
	logic                               src_is_reg_q;
	frx_pkg::reg_idx_t                  src_reg_q;
	frx_pkg::reg_t                      imm_q;
	logic                               target_valid_q;
	logic [15:0]                        jump_line_q;
	frx_pkg::reg_t                      cur_q;
	frx_pkg::reg_t                      res_q;
	frx_pkg::status_t                   status_q;
	logic                               taken_q;
	logic                               wr_q;

	frx_pkg::reg_t                      src_val;
	frx_pkg::alu_req_t                  alu_req;
	logic                               alu_done;
	frx_pkg::reg_t                      alu_result;
	logic                               in_accept;
	logic                               out_free;
	logic                               wb_go;
	logic                               jump_ok;
	frx_pkg::status_t                   cap_status;
	logic                               cap_taken;
	logic                               cap_wr;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign wb_go = (state_q == S_WB) && out_free;
	assign ram_we = wb_go && wr_q;

	// first read fetches the destination, second the source or CX for a jump
	always_comb begin
		raddr = dest_reg;
		if (state_q == S_RDS) begin
			raddr = (func_q == frx_pkg::OP_JNZ) ? frx_pkg::REG_CX : src_reg_q;
		end
	end

	frx_ram #(
		.WIDTH(frx_pkg::REG_WIDTH),
		.DEPTH(frx_pkg::NUM_REGS)
	) u_regs (
		.clk  (clk),
		.we   (ram_we),
		.waddr(dest_q),
		.wdata(res_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// a register never written since reset reads as zero
	assign rd_val = reg_valid_q[rd_idx_q] ? rdata : '0;
	assign src_val = src_is_reg_q ? rd_val : imm_q;

	assign alu_req = '{start: (state_q == S_CAP), op: func_q};

	frx_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.cur   (cur_q),
		.src   (src_val),
		.done  (alu_done),
		.result(alu_result)
	);

	assign jump_ok = !jump_line_q[15] && (jump_line_q < program_lines_q);

	// status and write-back decision in the capture step
	always_comb begin
		cap_status = frx_pkg::ST_OK;
		cap_taken = 1'b0;
		cap_wr = (func_q <= frx_pkg::OP_DEC);
		case (func_q)
			frx_pkg::OP_DIV: begin
				if (src_val == '0) begin
					cap_status = frx_pkg::ST_DIVZ;
					cap_wr = 1'b0;
				end
			end
			frx_pkg::OP_JNZ: begin
				// rd_val holds CX here
				if ((rd_val != '0) && target_valid_q) begin
					if (jump_ok) begin
						cap_taken = 1'b1;
					end else begin
						cap_status = frx_pkg::ST_SEGV;
					end
				end
			end
			frx_pkg::OP_END: cap_status = frx_pkg::ST_END;
			default: cap_status = frx_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			program_lines_q <= '0;
			reg_valid_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				program_lines_q <= cfg_wdata;
			end
			if (ram_we) begin
				reg_valid_q[dest_q] <= 1'b1;
			end
			if (wb_go) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_RDS;
					end
				end
				S_RDS: state_q <= S_CAP;
				S_CAP: state_q <= S_EXEC;
				S_EXEC: begin
					if (alu_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= raddr;
		if (in_accept) begin
			func_q <= func;
			dest_q <= dest_reg;
			src_is_reg_q <= src_is_reg;
			src_reg_q <= src_reg;
			imm_q <= frx_pkg::reg_t'(immediate);
			target_valid_q <= target_valid;
			jump_line_q <= jump_line;
		end
		if (state_q == S_RDS) begin
			cur_q <= rd_val;
		end
		if (state_q == S_CAP) begin
			status_q <= cap_status;
			taken_q <= cap_taken;
			wr_q <= cap_wr;
		end
		if ((state_q == S_EXEC) && alu_done) begin
			res_q <= alu_result;
		end
		if (wb_go) begin
			status <= status_q;
			jump_taken <= taken_q;
			jump_target <= taken_q ? jump_line_q : '0;
			dest_value <= frx_pkg::OUT_W'(signed'(res_q));
		end
	end

	a_alu_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> (state_q == S_EXEC))
		else $error("arithmetic unit finished outside the execute step");

	a_accept_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("second item accepted while one is in progress");

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_WB))
		else $error("result shown without a write-back step");

	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && jump_taken) |-> (status == frx_pkg::ST_OK))
		else $error("jump taken with a non-zero status");

endmodule

// ===== tb/instr_result_checker.sv =====
// result checker for the four-register executor: mirrors its registers and compares each result
module instr_result_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [3:0]            func,
	input  logic [1:0]            dest_reg,
	input  logic                  src_is_reg,
	input  logic [1:0]            src_reg,
	input  logic signed [31:0]    immediate,
	input  logic                  target_valid,
	input  logic signed [15:0]    jump_line,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [1:0]            status,
	input  logic                  jump_taken,
	input  logic [15:0]           jump_target,
	input  logic signed [31:0]    dest_value,
	output int                    pending,
	output int                    errors,
	output int                    n_checked,
	output int                    n_taken,
	output int                    n_segv,
	output int                    n_divz
);

	typedef struct {
		frx_pkg::status_t status;
		logic             taken;
		logic [15:0]      target;
		frx_pkg::reg_t    value;
	} exec_result_t;

	frx_pkg::reg_t gpr [frx_pkg::NUM_REGS];
	logic [15:0]   line_count;
	exec_result_t  awaited_results [$];

	// runs one instruction on the mirrored register file
	function automatic exec_result_t execute(input frx_pkg::func_t op,
			input frx_pkg::reg_idx_t d, input logic sr, input frx_pkg::reg_idx_t s,
			input frx_pkg::reg_t imm, input logic tv, input logic [15:0] jl);
		exec_result_t r;
		frx_pkg::reg_t src, cur, ma, mb, q;
		r.status = frx_pkg::ST_OK;
		r.taken = 1'b0;
		r.target = '0;
		src = sr ? gpr[s] : imm;
		cur = gpr[d];
		case (op)
			frx_pkg::OP_MOV: gpr[d] = src;
			frx_pkg::OP_ADD: gpr[d] = cur + src;
			frx_pkg::OP_SUB: gpr[d] = cur - src;
			frx_pkg::OP_MUL: gpr[d] = cur * src;
			frx_pkg::OP_DIV: begin
				if (src == '0) begin
					r.status = frx_pkg::ST_DIVZ;
				end else begin
					// magnitudes, unsigned quotient, then sign fix
					ma = cur[frx_pkg::REG_WIDTH-1] ? -cur : cur;
					mb = src[frx_pkg::REG_WIDTH-1] ? -src : src;
					q = ma / mb;
					gpr[d] = (cur[frx_pkg::REG_WIDTH-1] ^ src[frx_pkg::REG_WIDTH-1]) ? -q : q;
				end
			end
			frx_pkg::OP_INC: gpr[d] = cur + frx_pkg::reg_t'(1);
			frx_pkg::OP_DEC: gpr[d] = cur - frx_pkg::reg_t'(1);
			frx_pkg::OP_JNZ: begin
				if (gpr[frx_pkg::REG_CX] != '0 && tv) begin
					if (!jl[15] && jl < line_count) begin
						r.taken = 1'b1;
						r.target = jl;
					end else begin
						r.status = frx_pkg::ST_SEGV;
					end
				end
			end
			frx_pkg::OP_END: r.status = frx_pkg::ST_END;
			default: ;
		endcase
		r.value = gpr[d];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < frx_pkg::NUM_REGS; i++)
				gpr[i] = '0;
			line_count = '0;
			awaited_results.delete();
			pending <= 0;
			errors = 0;
			n_checked = 0;
			n_taken = 0;
			n_segv = 0;
			n_divz = 0;
		end else begin
			if (cfg_we)
				line_count = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result with no instruction outstanding: status %0d value %0h",
						status, dest_value);
					errors++;
				end else begin
					e = awaited_results.pop_front();
					n_checked++;
					if (e.taken) n_taken++;
					if (e.status == frx_pkg::ST_SEGV) n_segv++;
					if (e.status == frx_pkg::ST_DIVZ) n_divz++;
					if (status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, status);
						errors++;
					end
					if (jump_taken !== e.taken) begin
						$error("jump_taken: expected %0d, actual %0d", e.taken, jump_taken);
						errors++;
					end
					if (jump_target !== e.target) begin
						$error("jump_target: expected %0d, actual %0d", e.target, jump_target);
						errors++;
					end
					if (dest_value !== e.value) begin
						$error("dest_value: expected %0h, actual %0h", e.value, dest_value);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(execute(func, dest_reg, src_is_reg, src_reg,
					immediate, target_valid, jump_line));
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// top of the bench for the four-register executor: clock, reset, stimulus and verdict
module testbench;

	localparam frx_pkg::reg_idx_t R_AX = 2'd0;
	localparam frx_pkg::reg_idx_t R_BX = 2'd1;
	localparam frx_pkg::reg_idx_t R_CX = frx_pkg::REG_CX;
	localparam frx_pkg::reg_idx_t R_DX = 2'd3;
	localparam frx_pkg::func_t OP_UNUSED_LO = 4'd9;
	localparam frx_pkg::func_t OP_UNUSED_HI = 4'd15;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [15:0]       cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	frx_pkg::func_t    func = frx_pkg::OP_MOV;
	frx_pkg::reg_idx_t dest_reg = R_AX;
	logic              src_is_reg = 1'b0;
	frx_pkg::reg_idx_t src_reg = R_AX;
	frx_pkg::reg_t     immediate = '0;
	logic              target_valid = 1'b0;
	logic [15:0]       jump_line = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic              jump_taken;
	logic [15:0]       jump_target;
	logic [31:0]       dest_value;

	int pending, errors, n_checked, n_taken, n_segv, n_divz;
	int max_gap = 11;
	int lines_now = 0;

	always #1 clk = ~clk;

	four_register_instruction_executor i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .dest_reg(dest_reg), .src_is_reg(src_is_reg), .src_reg(src_reg),
		.immediate(immediate), .target_valid(target_valid), .jump_line(jump_line),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .jump_taken(jump_taken), .jump_target(jump_target),
		.dest_value(dest_value)
	);

	instr_result_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .dest_reg(dest_reg), .src_is_reg(src_is_reg), .src_reg(src_reg),
		.immediate(immediate), .target_valid(target_valid), .jump_line(jump_line),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .jump_taken(jump_taken), .jump_target(jump_target),
		.dest_value(dest_value),
		.pending(pending), .errors(errors), .n_checked(n_checked),
		.n_taken(n_taken), .n_segv(n_segv), .n_divz(n_divz)
	);

	task automatic issue(input frx_pkg::func_t f, input frx_pkg::reg_idx_t d, input logic sr,
			input frx_pkg::reg_idx_t s, input frx_pkg::reg_t imm, input logic tv,
			input logic [15:0] jl);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		dest_reg <= d;
		src_is_reg <= sr;
		src_reg <= s;
		immediate <= imm;
		target_valid <= tv;
		jump_line <= jl;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic op_imm(input frx_pkg::func_t f, input frx_pkg::reg_idx_t d,
			input frx_pkg::reg_t imm);
		issue(f, d, 1'b0, frx_pkg::reg_idx_t'($urandom_range(0, 3)), imm,
			1'($urandom_range(0, 1)), 16'($urandom()));
	endtask

	task automatic op_reg(input frx_pkg::func_t f, input frx_pkg::reg_idx_t d,
			input frx_pkg::reg_idx_t s);
		issue(f, d, 1'b1, s, $urandom(), 1'($urandom_range(0, 1)), 16'($urandom()));
	endtask

	task automatic jnz(input logic tv, input logic [15:0] jl);
		issue(frx_pkg::OP_JNZ, frx_pkg::reg_idx_t'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), frx_pkg::reg_idx_t'($urandom_range(0, 3)),
			$urandom(), tv, jl);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic set_lines(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lines_now = int'(v);
	endtask

	task automatic random_instr();
		frx_pkg::func_t f;
		frx_pkg::reg_t imm;
		logic [15:0] jl;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 6)
			f = frx_pkg::func_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else if (sel < 24)
			f = frx_pkg::OP_JNZ;
		else if (sel < 28)
			f = frx_pkg::OP_END;
		else
			f = frx_pkg::func_t'($urandom_range(frx_pkg::OP_MOV, frx_pkg::OP_DEC));
		case ($urandom_range(0, 5))
			0: imm = $urandom();
			1: imm = 32'h8000_0000;
			2: imm = 32'h7FFF_FFFF;
			3: imm = 32'hFFFF_FFFF;
			default: imm = frx_pkg::reg_t'($urandom_range(0, 16)) - frx_pkg::reg_t'(8);
		endcase
		// mostly targets from zero to just past the program bound, some negative, some anywhere
		case ($urandom_range(0, 3))
			0: jl = 16'($urandom());
			1: jl = 16'(0 - $urandom_range(1, 3));
			default: jl = 16'($urandom_range(0, lines_now + 2));
		endcase
		issue(f, frx_pkg::reg_idx_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			frx_pkg::reg_idx_t'($urandom_range(0, 3)), imm, $urandom_range(0, 9) != 0, jl);
	endtask

	// receiver: random stalls, quiet stretches, and two long hold-offs that back up the block
	initial begin
		int hold, got;
		got = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (got == 250 || got == 1100)
				hold = 300;
			else if ((got / 150) % 4 == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 11);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got++;
		end
	end

	initial begin
		logic [15:0] span;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_lines(16'd10);

		op_imm(frx_pkg::OP_MOV, R_AX, 32'h8000_0000);
		op_imm(frx_pkg::OP_MOV, R_BX, 32'hFFFF_FFFF);
		op_reg(frx_pkg::OP_DIV, R_AX, R_BX);              // most negative over minus one
		op_imm(frx_pkg::OP_MOV, R_CX, 32'h0);
		op_reg(frx_pkg::OP_DIV, R_DX, R_CX);              // divide by zero, register source
		op_imm(frx_pkg::OP_DIV, R_AX, 32'h0);             // divide by zero, immediate source
		jnz(1'b1, 16'd3);                                 // cx zero, no jump
		op_imm(frx_pkg::OP_INC, R_CX, $urandom());
		jnz(1'b0, 16'd3);                                 // non-numeric target
		jnz(1'b1, 16'd9);
		jnz(1'b1, 16'd0);
		jnz(1'b1, 16'd10);                                // target equal to the line count
		jnz(1'b1, 16'hFFFF);
		jnz(1'b1, 16'h8000);
		op_imm(frx_pkg::OP_MOV, R_DX, 32'h7FFF_FFFF);
		op_imm(frx_pkg::OP_ADD, R_DX, 32'h1);
		op_imm(frx_pkg::OP_SUB, R_DX, 32'h1);
		op_reg(frx_pkg::OP_MUL, R_DX, R_DX);
		op_imm(frx_pkg::OP_MUL, R_BX, 32'hFFFF_FFF9);
		op_imm(frx_pkg::OP_DIV, R_BX, 32'hFFFF_FFFD);     // truncation toward zero
		op_imm(frx_pkg::OP_DEC, R_AX, $urandom());
		op_reg(frx_pkg::OP_DIV, R_AX, R_BX);
		op_reg(frx_pkg::OP_MOV, R_CX, R_CX);
		issue(frx_pkg::OP_END, R_BX, 1'b1, R_DX, $urandom(), 1'b1, 16'd1);
		issue(OP_UNUSED_LO, R_DX, 1'b0, R_AX, $urandom(), 1'b1, 16'd2);
		issue(OP_UNUSED_HI, R_AX, 1'b1, R_BX, $urandom(), 1'b0, 16'd4);

		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: span = 16'd0;
				1: span = 16'hFFFF;
				2: span = 16'($urandom());
				3: span = 16'($urandom_range(1, 24));
				4: span = 16'd1;
				default: span = 16'h8000;
			endcase
			set_lines(span);
			case (p)
				1, 4: max_gap = 0;
				3: max_gap = 2;
				default: max_gap = 11;
			endcase
			op_imm(frx_pkg::OP_MOV, R_CX, 32'h1);
			jnz(1'b1, span - 16'd1);
			jnz(1'b1, span);
			for (int i = 0; i < 280; i++)
				random_instr();
		end

		wait_drained();
		repeat (60) @(posedge clk);
		$display("checked %0d instruction results across 7 program sizes, 0 to 65535 lines",
			n_checked);
		$display("%0d jumps taken, %0d segment violations, %0d divides by zero",
			n_taken, n_segv, n_divz);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout: %0d instructions still outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
